// File: rtl/wma_pkg.sv
// Shared widths and defaults for the windowed moving average.
package wma_pkg;

	localparam int SAMPLE_W    = 18;
	localparam int COUNT_OUT_W = 5;
	localparam int WINDOW_DEF  = 20;

	typedef enum logic [0:0] {
		MODE_PUSH  = 1'b0,
		MODE_CLEAR = 1'b1
	} mode_t;

endpackage

// File: rtl/wma_if.sv
// Valid/ready channel interfaces for readings and results.
interface wma_in_if;
	import wma_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [SAMPLE_W-1:0] sample;
	logic                sample_ok;

	modport source (output valid, mode, sample, sample_ok, input ready);
	modport sink   (input valid, mode, sample, sample_ok, output ready);
endinterface

interface wma_out_if;
	import wma_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_W-1:0]    average;
	logic [COUNT_OUT_W-1:0] fill_count;

	modport source (output valid, average, fill_count, input ready);
	modport sink   (input valid, average, fill_count, output ready);
endinterface

// File: rtl/windowed_moving_average_top.sv
// Top level of the windowed moving average over light readings.
// Every reading transfer yields one result: the truncated mean of the last WINDOW valid
// samples and the number held. One item at a time: a valid reading passes through S_UPD,
// S_GO, S_DIV and S_OUT, an ignored reading skips S_UPD, and a clear or any item that
// leaves the window empty goes from S_GO straight to S_OUT. The divider produces one
// quotient bit per cycle over the TOTAL_W-bit running total. Samples sit in a single-port
// ring memory with a registered read; the fill count decides when the oldest sample is read
// back, so the ring needs no clearing pass after reset or clear.
module windowed_moving_average_top #(
	parameter int WINDOW = wma_pkg::WINDOW_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wma_in_if.sink    reading,
	wma_out_if.source result
);
	import wma_pkg::*;

	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int TOTAL_W = SAMPLE_W + $clog2(WINDOW);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_UPD  = 5'b00010,
		S_GO   = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CNT_W-1:0]     count_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [SAMPLE_W-1:0]  avg_q;
	logic [SAMPLE_W-1:0]  old_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_avg_q;
	logic [COUNT_OUT_W-1:0] out_cnt_q;

	logic [SAMPLE_W-1:0]  ring_mem [WINDOW];

	logic                 accept;
	logic                 ring_full;
	logic                 div_start;
	logic                 div_done;
	logic [TOTAL_W-1:0]   div_quot;
	logic                 out_free;

	assign accept    = reading.valid && reading.ready;
	assign ring_full = (count_q == CNT_W'(WINDOW));
	assign div_start = (state_q == S_GO) && (count_q != '0);
	assign out_free  = !out_valid_q || result.ready;

	assign reading.ready     = (state_q == S_IDLE);
	assign result.valid      = out_valid_q;
	assign result.average    = out_avg_q;
	assign result.fill_count = out_cnt_q;

	wma_div #(
		.NUM_W(TOTAL_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(total_q),
		.divisor (count_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk) begin
		old_q <= ring_mem[slot_q];
		if (state_q == S_UPD) begin
			ring_mem[slot_q] <= sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= reading.sample;
		end
		if (state_q == S_GO && count_q == '0) begin
			avg_q <= '0;
		end else if (state_q == S_DIV && div_done) begin
			avg_q <= div_quot[SAMPLE_W-1:0];
		end
		if (state_q == S_OUT && out_free) begin
			out_avg_q <= avg_q;
			out_cnt_q <= COUNT_OUT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (reading.mode == MODE_CLEAR) begin
							slot_q  <= '0;
							count_q <= '0;
							total_q <= '0;
							state_q <= S_GO;
						end else if (reading.sample_ok) begin
							state_q <= S_UPD;
						end else begin
							state_q <= S_GO;
						end
					end
				end
				S_UPD: begin
					if (ring_full) begin
						total_q <= total_q - TOTAL_W'(old_q) + TOTAL_W'(sample_q);
					end else begin
						total_q <= total_q + TOTAL_W'(sample_q);
						count_q <= count_q + 1'b1;
					end
					slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					state_q <= S_GO;
				end
				S_GO: begin
					state_q <= (count_q == '0) ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/wma_div.sv
// Restoring divider, one quotient bit per cycle.
module wma_div #(
	parameter int NUM_W = 23,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [NUM_W-1:0]  acc_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= STEP_W'(NUM_W);
			done_q <= 1'b0;
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
			done_q <= (step_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (step_q != '0) begin
			acc_q <= {acc_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

// File: tb/sv/wma_mean_checker.sv
// Watches both channels, predicts each windowed mean and compares it with the block's result.
module wma_mean_checker #(
	parameter int WINDOW = wma_pkg::WINDOW_DEF
) (
	input  logic clk,
	input  logic arst_n,
	wma_in_if    reading,
	wma_out_if   result,
	output int   mismatch_count,
	output int   pending_means
);
	import wma_pkg::*;

	localparam int TOTAL_W = SAMPLE_W + $clog2(WINDOW + 1);

	typedef struct packed {
		logic [SAMPLE_W-1:0]    average;
		logic [COUNT_OUT_W-1:0] fill_count;
	} window_mean_t;

	logic [SAMPLE_W-1:0] ring [WINDOW];
	int unsigned         slot;
	int unsigned         held;
	logic [TOTAL_W-1:0]  total;
	window_mean_t        expected_means [$];
	window_mean_t        want;
	int                  mismatches;

	function automatic window_mean_t window_mean_after(input mode_t m,
			input logic [SAMPLE_W-1:0] value, input logic ok);
		window_mean_t       r;
		int unsigned        at;
		logic [TOTAL_W-1:0] quotient;
		if (m == MODE_CLEAR) begin
			for (int i = 0; i < WINDOW; i++)
				ring[i] = '0;
			slot  = 0;
			held  = 0;
			total = '0;
		end else if (ok) begin
			at = (slot < WINDOW) ? slot : 0;
			if (held < WINDOW) begin
				total = total + TOTAL_W'(value);
				held++;
			end else begin
				total = total - TOTAL_W'(ring[at]) + TOTAL_W'(value);
			end
			ring[at] = value;
			at++;
			slot = (at >= WINDOW) ? 0 : at;
		end
		quotient     = (held != 0) ? total / TOTAL_W'(held) : '0;
		r.average    = quotient[SAMPLE_W-1:0];
		r.fill_count = held[COUNT_OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++)
				ring[i] = '0;
			slot  = 0;
			held  = 0;
			total = '0;
			expected_means.delete();
			mismatches    = 0;
			pending_means = 0;
		end else begin
			if (reading.valid && reading.ready)
				expected_means.push_back(window_mean_after(mode_t'(reading.mode),
					reading.sample, reading.sample_ok));
			if (result.valid && result.ready) begin
				if (expected_means.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: average %0d fill_count %0d",
							result.average, result.fill_count);
					mismatches++;
				end else begin
					want = expected_means.pop_front();
					if (result.average !== want.average ||
							result.fill_count !== want.fill_count) begin
						if (mismatches < 10)
							$display("result differs: average %0d/%0d fill_count %0d/%0d",
								want.average, result.average,
								want.fill_count, result.fill_count);
						mismatches++;
					end
				end
			end
			pending_means = expected_means.size();
		end
	end

	assign mismatch_count = mismatches;

endmodule

// File: tb/sv/tb.sv
// Testbench top: clock, reset, reading stimulus, result back-pressure and the verdict.
module tb;
	import wma_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	int   sent;
	int   mismatch_count;
	int   pending_means;
	bit   sender_steady;

	wma_in_if  reading ();
	wma_out_if result ();

	windowed_moving_average_top #(.WINDOW(WINDOW_DEF)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.reading(reading),
		.result (result)
	);

	wma_mean_checker #(.WINDOW(WINDOW_DEF)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.reading       (reading),
		.result        (result),
		.mismatch_count(mismatch_count),
		.pending_means (pending_means)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return SAMPLE_W'($urandom_range(0, 15));
			3: return SAMPLE_W'(18'h3FFFF - $urandom_range(0, 15));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_reading(input mode_t m, input logic [SAMPLE_W-1:0] value,
			input logic ok);
		int gap;
		@(negedge clk);
		reading.valid     <= 1'b1;
		reading.mode      <= m;
		reading.sample    <= value;
		reading.sample_ok <= ok;
		@(posedge clk);
		while (!reading.ready)
			@(posedge clk);
		sent++;
		gap = sender_steady ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk);
			reading.valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	initial begin
		int counted;
		int pick;
		int run_len;
		logic ok;
		reading.valid     = 1'b0;
		reading.mode      = MODE_PUSH;
		reading.sample    = '0;
		reading.sample_ok = 1'b0;
		arst_n            = 1'b0;
		sent              = 0;
		sender_steady     = 1'b0;
		counted           = 0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_reading(MODE_CLEAR, '1, 1'b1);
		send_reading(MODE_PUSH, 18'h15555, 1'b0);
		repeat (WINDOW_DEF)
			send_reading(MODE_PUSH, '1, 1'b1);
		send_reading(MODE_PUSH, '0, 1'b1);
		send_reading(MODE_PUSH, 18'h2AAAA, 1'b0);
		send_reading(MODE_CLEAR, '0, 1'b0);

		while (counted < 1450) begin
			pick          = $urandom_range(0, 99);
			sender_steady = ($urandom_range(0, 4) == 0);
			if (pick < 10) begin
				send_reading(MODE_CLEAR, SAMPLE_W'($urandom), 1'($urandom));
				counted++;
			end
			if (pick < 75) begin
				run_len = $urandom_range(1, 45);
				repeat (run_len) begin
					ok = ($urandom_range(0, 11) != 0);
					send_reading(MODE_PUSH, pick_sample(), ok);
					counted++;
				end
			end else if (pick < 85) begin
				run_len = $urandom_range(WINDOW_DEF, WINDOW_DEF + 10);
				repeat (run_len) begin
					send_reading(MODE_PUSH, '1, 1'b1);
					counted++;
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					send_reading(mode_t'($urandom_range(0, 1)), SAMPLE_W'($urandom),
						1'($urandom_range(0, 1)));
					counted++;
				end
			end
		end

		@(negedge clk);
		reading.valid <= 1'b0;
		while (pending_means != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (mismatch_count == 0 && pending_means == 0)
			$display("windowed_moving_average_top: match");
		else
			$display("windowed_moving_average_top: mismatch");
		$finish;
	end

	initial begin
		int  high_len;
		int  low_len;
		bit  pressure_done;
		result.ready  = 1'b0;
		pressure_done = 1'b0;
		wait (arst_n);
		forever begin
			high_len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 8);
			low_len  = idle_len();
			if (!pressure_done && sent >= 400) begin
				pressure_done = 1'b1;
				low_len       = 500;
			end
			@(negedge clk);
			result.ready <= 1'b1;
			repeat (high_len - 1)
				@(negedge clk);
			if (low_len > 0) begin
				@(negedge clk);
				result.ready <= 1'b0;
				repeat (low_len - 1)
					@(negedge clk);
			end
		end
	end

	initial begin
		#30_000_000;
		$display("windowed_moving_average_top: mismatch");
		$finish;
	end

endmodule
